FILE: hdl/aet_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the arithmetic expression tokenizer.
// Used by every module of the block; depends on nothing.
package aet_pkg;

  localparam logic [1:0] KIND_NUMBER   = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_VARIABLE = 2'd2;

  localparam logic [2:0] OP_PLUS   = 3'd0;
  localparam logic [2:0] OP_MINUS  = 3'd1;
  localparam logic [2:0] OP_UMINUS = 3'd2;
  localparam logic [2:0] OP_MULT   = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_POW    = 3'd5;
  localparam logic [2:0] OP_LPAREN = 3'd6;
  localparam logic [2:0] OP_RPAREN = 3'd7;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [1:0]  token_kind;
    logic [2:0]  operator_code;
    logic [7:0]  variable_char;
    logic [63:0] number_value;
    logic        last_of_run;
  } token_t;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_OPERATOR,
    CLS_LETTER,
    CLS_OTHER,
    CLS_EOT
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [2:0]  op;
    logic [7:0]  ch;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

FILE: hdl/aet_front.sv
`timescale 1ns / 1ps
// Front end: classifies each input character and holds it in a two-entry
// command queue for the back end. Depends on aet_pkg.
module aet_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  aet_pkg::item_t      item,
  output aet_pkg::cmd_chan_t  cmd_out,
  input  logic                take
);
  import aet_pkg::*;

  cmd_t       mem [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  cmd_t       cmd_new;
  logic       is_space;
  logic       wr_en;
  logic       rd_en;

  always_comb begin
    cmd_new.ch  = item.char_code;
    cmd_new.op  = OP_PLUS;
    cmd_new.cls = CLS_OTHER;
    is_space    = 1'b0;
    if (item.end_of_text) begin
      cmd_new.cls = CLS_EOT;
    end else if (item.char_code == CH_SPACE) begin
      is_space = 1'b1;
    end else if (item.char_code >= CH_ZERO && item.char_code <= CH_NINE) begin
      cmd_new.cls = CLS_DIGIT;
    end else if ((item.char_code >= CH_LOW_A && item.char_code <= CH_LOW_Z && item.char_code != CH_U)
                 || (item.char_code >= CH_UP_A && item.char_code <= CH_UP_Z)) begin
      cmd_new.cls = CLS_LETTER;
    end else begin
      unique case (item.char_code)
        CH_PLUS:   begin cmd_new.cls = CLS_OPERATOR; cmd_new.op = OP_PLUS;   end
        CH_MINUS:  begin cmd_new.cls = CLS_OPERATOR; cmd_new.op = OP_MINUS;  end
        CH_U:      begin cmd_new.cls = CLS_OPERATOR; cmd_new.op = OP_UMINUS; end
        CH_STAR:   begin cmd_new.cls = CLS_OPERATOR; cmd_new.op = OP_MULT;   end
        CH_SLASH:  begin cmd_new.cls = CLS_OPERATOR; cmd_new.op = OP_DIV;    end
        CH_CARET:  begin cmd_new.cls = CLS_OPERATOR; cmd_new.op = OP_POW;    end
        CH_LPAREN: begin cmd_new.cls = CLS_OPERATOR; cmd_new.op = OP_LPAREN; end
        CH_RPAREN: begin cmd_new.cls = CLS_OPERATOR; cmd_new.op = OP_RPAREN; end
        default:   cmd_new.cls = CLS_OTHER;
      endcase
    end
  end

  assign full          = (count == 2'd2);
  assign wr_en         = push && !full && !is_space;
  assign rd_en         = take && (count != 2'd0);
  assign cmd_out.valid = (count != 2'd0);
  assign cmd_out.cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= cmd_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/aet_back.sv
`timescale 1ns / 1ps
// Back end: keeps the decimal accumulator and pending flag and turns each
// classified command into zero, one or two tokens. Depends on aet_pkg.
module aet_back (
  input  logic                clk,
  input  logic                rst,
  input  aet_pkg::cmd_chan_t  cmd_in,
  output logic                take,
  output logic                tok_valid,
  output aet_pkg::token_t     tok,
  input  logic                tok_ready
);
  import aet_pkg::*;

  logic [63:0] acc;
  logic [63:0] acc_next;
  logic        pending;
  logic        pending_next;
  logic        is_symbol;
  logic        emit_num;
  logic        emit_sym;

  assign is_symbol = (cmd_in.cmd.cls == CLS_OPERATOR) || (cmd_in.cmd.cls == CLS_LETTER);
  assign emit_num  = cmd_in.valid && pending && (cmd_in.cmd.cls != CLS_DIGIT);
  assign emit_sym  = cmd_in.valid && !pending && is_symbol;
  assign tok_valid = emit_num || emit_sym;
  assign take      = cmd_in.valid && (tok_valid ? (tok_ready && !(emit_num && is_symbol)) : 1'b1);

  always_comb begin
    tok = '0;
    if (emit_num) begin
      tok.token_kind   = KIND_NUMBER;
      tok.number_value = acc;
      tok.last_of_run  = !is_symbol;
    end else if (cmd_in.cmd.cls == CLS_OPERATOR) begin
      tok.token_kind    = KIND_OPERATOR;
      tok.operator_code = cmd_in.cmd.op;
      tok.last_of_run   = 1'b1;
    end else begin
      tok.token_kind    = KIND_VARIABLE;
      tok.variable_char = cmd_in.cmd.ch;
      tok.last_of_run   = 1'b1;
    end
  end

  always_comb begin
    acc_next     = acc;
    pending_next = pending;
    if (cmd_in.valid && cmd_in.cmd.cls == CLS_DIGIT) begin
      acc_next     = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} + {60'd0, cmd_in.cmd.ch[3:0]};
      pending_next = 1'b1;
    end else if ((emit_num && tok_ready) || (take && cmd_in.cmd.cls == CLS_EOT)) begin
      acc_next     = '0;
      pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      pending <= 1'b0;
    end else begin
      acc     <= acc_next;
      pending <= pending_next;
    end
  end

endmodule

FILE: hdl/aet_token_queue.sv
`timescale 1ns / 1ps
// Two-entry result queue that holds tokens until the consumer pops them.
// Depends on aet_pkg.
module aet_token_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  input  aet_pkg::token_t  tok,
  output logic             tok_ready,
  output logic             empty,
  input  logic             pop,
  output aet_pkg::token_t  token
);
  import aet_pkg::*;

  token_t     mem [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       wr_en;
  logic       rd_en;

  assign tok_ready = (count != 2'd2);
  assign empty     = (count == 2'd0);
  assign wr_en     = tok_valid && tok_ready;
  assign rd_en     = pop && !empty;
  assign token     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/arith_expression_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the arithmetic expression tokenizer: front end, back end and
// result queue. Depends on aet_pkg, aet_front, aet_back and aet_token_queue.
//
// One character beat is accepted per clock while full is low; spaces are
// dropped at the input. The back end handles one character per cycle, except
// that a character that yields a token waits while the result queue is full,
// and an operator or letter ending a pending number is held back while the
// number token enters the result queue ahead of the symbol token. Tokens
// pass through the registered command queue and then the result queue.
// Numbers accumulate in 64 bits and wrap silently.
module arith_expression_tokenizer (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  aet_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output aet_pkg::token_t  token
);
  import aet_pkg::*;

  cmd_chan_t cmd_chan;
  logic      take;
  logic      tok_valid;
  token_t    tok;
  logic      tok_ready;

  aet_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .cmd_out (cmd_chan),
    .take    (take)
  );

  aet_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_in    (cmd_chan),
    .take      (take),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_ready (tok_ready)
  );

  aet_token_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_ready (tok_ready),
    .empty     (empty),
    .pop       (pop),
    .token     (token)
  );

  a_reset_empty : assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_value_only_numbers : assert property (@(posedge clk) disable iff (rst)
    (!empty && token.token_kind != KIND_NUMBER) |-> (token.number_value == 64'd0))
    else $error("non-number token carries a value");

  a_number_not_last_needs_symbol : assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_ready && tok.token_kind == KIND_NUMBER && !tok.last_of_run)
    |=> (tok_valid && tok.token_kind != KIND_NUMBER && tok.last_of_run))
    else $error("number token not followed by its symbol token");

endmodule

FILE: sim/aet_token_checker.sv
`timescale 1ns / 1ps
// Token checker for the arithmetic expression tokenizer: watches both queue
// ports, predicts the tokens of every accepted character and compares them.
// Depends on aet_pkg.
module aet_token_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  aet_pkg::item_t   item,
  input  logic             empty,
  input  logic             pop,
  input  aet_pkg::token_t  token,
  output int               failures,
  output int               outstanding
);
  import aet_pkg::*;

  logic [63:0] acc_value;
  logic        digits_seen;
  token_t      awaited_tokens[$];

  function automatic token_t make_token(input logic [1:0] kind, input logic [2:0] op,
                                        input logic [7:0] letter, input logic [63:0] value);
    token_t t;
    t.token_kind    = kind;
    t.operator_code = op;
    t.variable_char = letter;
    t.number_value  = value;
    t.last_of_run   = 1'b0;
    return t;
  endfunction

  function automatic void tokenize_char(input item_t beat);
    token_t     run[2];
    int         n;
    logic       is_op;
    logic [2:0] op;
    logic [7:0] c;
    n = 0;
    c = beat.char_code;
    is_op = 1'b1;
    op = OP_PLUS;
    if (beat.end_of_text) begin
      if (digits_seen) begin
        run[n] = make_token(KIND_NUMBER, OP_PLUS, 8'd0, acc_value);
        n++;
      end
      acc_value   = '0;
      digits_seen = 1'b0;
    end else if (c == CH_SPACE) begin
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      acc_value   = acc_value * 64'd10 + {56'd0, c - CH_ZERO};
      digits_seen = 1'b1;
    end else begin
      if (digits_seen) begin
        run[n] = make_token(KIND_NUMBER, OP_PLUS, 8'd0, acc_value);
        n++;
        acc_value   = '0;
        digits_seen = 1'b0;
      end
      case (c)
        CH_PLUS:   op = OP_PLUS;
        CH_MINUS:  op = OP_MINUS;
        CH_U:      op = OP_UMINUS;
        CH_STAR:   op = OP_MULT;
        CH_SLASH:  op = OP_DIV;
        CH_CARET:  op = OP_POW;
        CH_LPAREN: op = OP_LPAREN;
        CH_RPAREN: op = OP_RPAREN;
        default:   is_op = 1'b0;
      endcase
      if (is_op) begin
        run[n] = make_token(KIND_OPERATOR, op, 8'd0, 64'd0);
        n++;
      end else if ((c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
        run[n] = make_token(KIND_VARIABLE, OP_PLUS, c, 64'd0);
        n++;
      end
    end
    if (n > 0) begin
      run[n-1].last_of_run = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      awaited_tokens.push_back(run[i]);
    end
  endfunction

  always @(posedge clk) begin
    token_t want;
    int     bad;
    bad = 0;
    if (rst) begin
      acc_value   = '0;
      digits_seen = 1'b0;
      awaited_tokens.delete();
      failures    <= 0;
      outstanding <= 0;
    end else begin
      if (push && !full) begin
        tokenize_char(item);
      end
      if (pop && !empty) begin
        if (awaited_tokens.size() == 0) begin
          $error("token_kind: expected no token, got %0d", token.token_kind);
          bad = 1;
        end else begin
          want = awaited_tokens.pop_front();
          if (token.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind, token.token_kind);
            bad = 1;
          end
          if (token.operator_code !== want.operator_code) begin
            $error("operator_code: expected %0d, got %0d",
                   want.operator_code, token.operator_code);
            bad = 1;
          end
          if (token.variable_char !== want.variable_char) begin
            $error("variable_char: expected 0x%02h, got 0x%02h",
                   want.variable_char, token.variable_char);
            bad = 1;
          end
          if (token.number_value !== want.number_value) begin
            $error("number_value: expected %0d, got %0d",
                   want.number_value, token.number_value);
            bad = 1;
          end
          if (token.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, token.last_of_run);
            bad = 1;
          end
        end
      end
      failures    <= failures + bad;
      outstanding <= awaited_tokens.size();
    end
  end

endmodule

FILE: sim/arith_expression_tokenizer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the arithmetic expression tokenizer: drives character
// beats and token pops, and gives the verdict. Depends on aet_pkg, the block
// and aet_token_checker.
module arith_expression_tokenizer_tb;
  import aet_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_CHARS   = 900;
  localparam int QUIET_TAIL     = 150;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   push = 1'b0;
  logic   full;
  item_t  item = '0;
  logic   empty;
  logic   pop = 1'b0;
  token_t token;

  int     failures;
  int     outstanding;
  logic   idle_on = 1'b1;
  int     chars_sent = 0;
  int     pop_stall = 0;
  int     quiet_cycles = 0;

  always #6 clk = ~clk;

  arith_expression_tokenizer uut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .empty (empty),
    .pop   (pop),
    .token (token)
  );

  aet_token_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .token       (token),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_stall <= 0;
    end else if (pop_stall != 0) begin
      pop <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      pop <= 1'b0;
      pop_stall <= $urandom_range(0, 14);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eot);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{char_code: c, end_of_text: eot};
    @(posedge clk);
    while (full) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_number(input logic [63:0] value);
    logic [3:0] digit[20];
    int         n;
    n = 0;
    do begin
      digit[n] = 4'(value % 64'd10);
      value = value / 64'd10;
      n++;
    end while (value != 0);
    for (int i = n - 1; i >= 0; i--) begin
      send_char(CH_ZERO + digit[i], 1'b0);
    end
  endtask

  task automatic send_expression();
    int         parts;
    int         sel;
    int         len;
    logic [7:0] c;
    parts = $urandom_range(1, 12);
    repeat (parts) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        if ($urandom_range(0, 14) == 0) begin
          send_number($urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 4);
          repeat (len) send_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
      end else if (sel < 47) begin
        c = $urandom_range(0, 1) ? CH_LOW_A : CH_UP_A;
        send_char(c + 8'($urandom_range(0, 25)), 1'b0);
      end else if (sel < 80) begin
        case ($urandom_range(0, 7))
          0: c = CH_PLUS;
          1: c = CH_MINUS;
          2: c = CH_U;
          3: c = CH_STAR;
          4: c = CH_SLASH;
          5: c = CH_CARET;
          6: c = CH_LPAREN;
          default: c = CH_RPAREN;
        endcase
        send_char(c, 1'b0);
      end else if (sel < 92) begin
        repeat ($urandom_range(1, 3)) send_char(CH_SPACE, 1'b0);
      end else begin
        send_char(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      send_char(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    string directed_text;
    int    random_start;
    directed_text = "007 9+-u*/^()AZaz";
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_char(8'h00, 1'b1);
    for (int i = 0; i < directed_text.len(); i++) begin
      send_char(directed_text[i], 1'b0);
    end
    send_char("5", 1'b0);
    send_char(8'h00, 1'b0);
    send_char("3", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("4", 1'b0);
    send_char(8'hFF, 1'b1);

    random_start = chars_sent;
    while (chars_sent - random_start < RANDOM_CHARS) begin
      idle_on = (chars_sent - random_start < RANDOM_CHARS - QUIET_TAIL) &&
                (((chars_sent - random_start) / 60) % 4 != 3);
      send_expression();
    end
    send_char(8'h00, 1'b1);

    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
